// File: sv/fit_policy_segment_allocator_defines.svh
// Assertion macros used by the segment allocator datapath.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define FPSA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fpsa_pkg.sv
// Shared types and codes of the segment allocator.
package fpsa_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_BADFREE = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  typedef enum logic [3:0] {
    C_NONE, C_INIT, C_START, C_READ, C_EVAL, C_ALLOC_PREP, C_SH_READ, C_SH_WRITE,
    C_SPLIT_HI, C_ALLOC_WR, C_RD_NEXT, C_MERGE, C_MSH_READ, C_MSH_WRITE, C_MDONE,
    C_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic req_zero;
    logic is_free;
    logic scan_last;
    logic pick_valid;
    logic need_split;
    logic table_full;
    logic hit_valid;
    logic shift_more;
    logic mshift_more;
  } dp_stat_t;

endpackage

// File: sv/fpsa_dp.sv
// Datapath of the segment allocator: segment table memory, scan and edit registers.
`include "fit_policy_segment_allocator_defines.svh"

module fpsa_dp import fpsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int UNIT_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pool_size_we_i,
  input  logic [UNIT_BITS-1:0] pool_size_i,
  input  logic                 op_i,
  input  logic [1:0]           fit_policy_i,
  input  logic [UNIT_BITS-1:0] req_size_i,
  input  logic [UNIT_BITS-1:0] block_offset_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [UNIT_BITS-1:0] granted_offset_o,
  output logic [UNIT_BITS-1:0] granted_size_o
);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int UB    = UNIT_BITS;
  localparam logic [UB-1:0]    PoolReset = UB'(1000);
  localparam logic [CNT_W-1:0] CntOne    = CNT_W'(1);
  localparam logic [CNT_W-1:0] CntMax    = CNT_W'(MAX_SEGMENTS);

  // entry word: {used, size}
  logic [UB:0] mem [MAX_SEGMENTS];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [UB:0]       wr_data, rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  logic [UB-1:0]    pool_q, nf_q;
  logic [CNT_W-1:0] count_q;
  logic             done_q;
  logic             op_q;
  policy_e          pol_q;
  logic [UB-1:0]    req_q, off_q, acc_q;
  logic [CNT_W-1:0] idx_q, j_q;
  logic [1:0]       r_q;
  logic             last_used_q;
  logic [UB-1:0]    last_size_q, last_acc_q;
  logic             prev_used_q;
  logic [UB-1:0]    prev_size_q, prev_acc_q;
  logic             hit_valid_q;
  logic [CNT_W-1:0] hit_idx_q;
  logic [UB-1:0]    hit_acc_q, hit_size_q;
  logic             best_valid_q, aft_valid_q, cov_q;
  logic [CNT_W-1:0] best_idx_q, aft_idx_q;
  logic [UB-1:0]    best_size_q, best_acc_q, aft_size_q, aft_acc_q;
  logic [UB-1:0]    res_off_q, res_size_q;
  logic [2:0]       status_q;
  logic [UB-1:0]    gout_off_q, gout_size_q;

  logic [UB-1:0] rd_size;
  logic          rd_used;
  assign rd_size = rd_q[UB-1:0];
  assign rd_used = rd_q[UB];

  // scan evaluation of the entry at idx_q
  logic [UB:0] end_sum;
  logic covers, fit, best_upd, aft_upd, hit;
  assign end_sum = {1'b0, acc_q} + {1'b0, rd_size};
  assign covers  = (nf_q >= acc_q) && ({1'b0, nf_q} < end_sum);
  assign fit     = !rd_used && (rd_size >= req_q);
  assign aft_upd = fit && (cov_q || covers) && !aft_valid_q;
  assign hit     = !hit_valid_q && (acc_q == off_q) && rd_used && (rd_size != '0);

  always_comb begin
    unique case (pol_q)
      POL_BEST:  best_upd = fit && (!best_valid_q || rd_size < best_size_q);
      POL_WORST: best_upd = fit && (!best_valid_q || rd_size > best_size_q);
      default:   best_upd = fit && !best_valid_q;
    endcase
  end

  // next fit prefers the first fit at or after the covering segment
  logic             use_aft;
  logic [CNT_W-1:0] pick_idx, pick_idx1;
  logic [UB-1:0]    pick_size, pick_acc;
  assign use_aft   = (pol_q == POL_NEXT) && aft_valid_q;
  assign pick_idx  = use_aft ? aft_idx_q  : best_idx_q;
  assign pick_size = use_aft ? aft_size_q : best_size_q;
  assign pick_acc  = use_aft ? aft_acc_q  : best_acc_q;
  assign pick_idx1 = pick_idx + CntOne;

  // free merge
  logic             left, right;
  logic [CNT_W-1:0] hit_idx1, merge_t, jm1;
  logic [UB-1:0]    merge_size, merge_off;
  logic [1:0]       merge_r;
  logic [CNT_W:0]   j_plus_r;
  assign hit_idx1   = hit_idx_q + CntOne;
  assign left       = (hit_idx_q != '0) && !prev_used_q;
  assign right      = (hit_idx1 < count_q) && !rd_used;
  assign merge_size = hit_size_q + (left ? prev_size_q : '0) + (right ? rd_size : '0);
  assign merge_off  = left ? prev_acc_q : hit_acc_q;
  assign merge_t    = left ? hit_idx_q - CntOne : hit_idx_q;
  assign merge_r    = {1'b0, left} + {1'b0, right};
  assign j_plus_r   = {1'b0, j_q} + {{(CNT_W-1){1'b0}}, r_q};
  assign jm1        = j_q - CntOne;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_q[IDX_W-1:0];
    wr_data = rd_q;
    rd_addr = idx_q[IDX_W-1:0];
    unique case (cmd_i.op)
      C_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b0, pool_q};
      end
      C_SH_READ:   rd_addr = jm1[IDX_W-1:0];
      C_SH_WRITE:  wr_en = 1'b1;
      C_SPLIT_HI: begin
        wr_en   = 1'b1;
        wr_addr = pick_idx1[IDX_W-1:0];
        wr_data = {1'b0, pick_size - req_q};
      end
      C_ALLOC_WR: begin
        wr_en   = 1'b1;
        wr_addr = pick_idx[IDX_W-1:0];
        wr_data = {1'b1, req_q};
      end
      C_RD_NEXT:   rd_addr = hit_idx1[IDX_W-1:0];
      C_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = merge_t[IDX_W-1:0];
        wr_data = {1'b0, merge_size};
      end
      C_MSH_READ:  rd_addr = j_plus_r[IDX_W-1:0];
      C_MSH_WRITE: wr_en = 1'b1;
      default: ;
    endcase
  end

  // table bookkeeping and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= PoolReset;
      count_q <= CntOne;
      nf_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == C_RESULT);
      if (pool_size_we_i) pool_q <= pool_size_i;
      unique case (cmd_i.op)
        C_INIT: begin
          count_q <= CntOne;
          nf_q    <= '0;
        end
        C_SPLIT_HI: count_q <= count_q + CntOne;
        C_ALLOC_WR: nf_q <= pick_acc;
        C_MDONE:    count_q <= count_q - {{(CNT_W-2){1'b0}}, r_q};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      C_START: begin
        op_q         <= op_i;
        pol_q        <= policy_e'(fit_policy_i);
        req_q        <= req_size_i;
        off_q        <= block_offset_i;
        idx_q        <= '0;
        acc_q        <= '0;
        best_valid_q <= 1'b0;
        aft_valid_q  <= 1'b0;
        cov_q        <= 1'b0;
        hit_valid_q  <= 1'b0;
        last_used_q  <= 1'b1;
      end
      C_EVAL: begin
        idx_q       <= idx_q + CntOne;
        acc_q       <= end_sum[UB-1:0];
        last_used_q <= rd_used;
        last_size_q <= rd_size;
        last_acc_q  <= acc_q;
        if (covers) cov_q <= 1'b1;
        if (best_upd) begin
          best_valid_q <= 1'b1;
          best_idx_q   <= idx_q;
          best_size_q  <= rd_size;
          best_acc_q   <= acc_q;
        end
        if (aft_upd) begin
          aft_valid_q <= 1'b1;
          aft_idx_q   <= idx_q;
          aft_size_q  <= rd_size;
          aft_acc_q   <= acc_q;
        end
        if (hit) begin
          hit_valid_q <= 1'b1;
          hit_idx_q   <= idx_q;
          hit_acc_q   <= acc_q;
          hit_size_q  <= rd_size;
          prev_used_q <= last_used_q;
          prev_size_q <= last_size_q;
          prev_acc_q  <= last_acc_q;
        end
      end
      C_ALLOC_PREP: j_q <= count_q;
      C_SH_WRITE:   j_q <= jm1;
      C_ALLOC_WR: begin
        res_off_q  <= pick_acc;
        res_size_q <= req_q;
      end
      C_MERGE: begin
        j_q        <= merge_t + CntOne;
        r_q        <= merge_r;
        res_off_q  <= merge_off;
        res_size_q <= merge_size;
      end
      C_MSH_WRITE: j_q <= j_q + CntOne;
      C_RESULT: begin
        status_q    <= cmd_i.st;
        gout_off_q  <= (cmd_i.st == ST_OK) ? res_off_q  : '0;
        gout_size_q <= (cmd_i.st == ST_OK) ? res_size_q : '0;
      end
      default: ;
    endcase
  end

  assign stat_o.req_zero    = (req_q == '0);
  assign stat_o.is_free     = op_q;
  assign stat_o.scan_last   = ((idx_q + CntOne) == count_q);
  assign stat_o.pick_valid  = best_valid_q;
  assign stat_o.need_split  = (pick_size > req_q);
  assign stat_o.table_full  = (count_q == CntMax);
  assign stat_o.hit_valid   = hit_valid_q;
  assign stat_o.shift_more  = (j_q > pick_idx1);
  assign stat_o.mshift_more = (j_plus_r < {1'b0, count_q});

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_offset_o = gout_off_q;
  assign granted_size_o   = gout_size_q;

  `FPSA_ASSERT(a_count_range, (count_q != '0) && (count_q <= CntMax), "segment count out of range")
  `FPSA_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result word strobed twice")
  `FPSA_ASSERT_NEXT(a_split_room, cmd_i.op == C_SPLIT_HI, count_q != '0 && count_q <= CntMax,
    "split overflowed the table")

endmodule

// File: sv/fpsa_ctrl.sv
// Controller state machine of the segment allocator.
module fpsa_ctrl import fpsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     pool_size_we_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);
  typedef enum logic [13:0] {
    S_INIT   = 14'h0001,
    S_IDLE   = 14'h0002,
    S_RD     = 14'h0004,
    S_EVAL   = 14'h0008,
    S_DECIDE = 14'h0010,
    S_SHR    = 14'h0020,
    S_SHW    = 14'h0040,
    S_AWHI   = 14'h0080,
    S_AWLO   = 14'h0100,
    S_FNRD   = 14'h0200,
    S_FMRG   = 14'h0400,
    S_MSR    = 14'h0800,
    S_MSW    = 14'h1000,
    S_RESULT = 14'h2000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  cmd_e    op;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    op      = C_NONE;
    unique case (state_q)
      S_INIT: begin
        op      = C_INIT;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op      = C_START;
          state_d = S_RD;
        end else if (pool_size_we_i) begin
          state_d = S_INIT;
        end
      end
      S_RD: begin
        op      = C_READ;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        op      = C_EVAL;
        state_d = stat_i.scan_last ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        if (stat_i.is_free) begin
          if (!stat_i.hit_valid) begin
            st_d    = ST_BADFREE;
            state_d = S_RESULT;
          end else begin
            state_d = S_FNRD;
          end
        end else if (stat_i.req_zero) begin
          st_d    = ST_ZERO;
          state_d = S_RESULT;
        end else if (!stat_i.pick_valid) begin
          st_d    = ST_NOFIT;
          state_d = S_RESULT;
        end else if (stat_i.need_split && stat_i.table_full) begin
          st_d    = ST_FULL;
          state_d = S_RESULT;
        end else if (stat_i.need_split) begin
          op      = C_ALLOC_PREP;
          state_d = S_SHR;
        end else begin
          state_d = S_AWLO;
        end
      end
      // open a hole above the picked segment, top entry first
      S_SHR: begin
        if (stat_i.shift_more) begin
          op      = C_SH_READ;
          state_d = S_SHW;
        end else begin
          state_d = S_AWHI;
        end
      end
      S_SHW: begin
        op      = C_SH_WRITE;
        state_d = S_SHR;
      end
      S_AWHI: begin
        op      = C_SPLIT_HI;
        state_d = S_AWLO;
      end
      S_AWLO: begin
        op      = C_ALLOC_WR;
        st_d    = ST_OK;
        state_d = S_RESULT;
      end
      S_FNRD: begin
        op      = C_RD_NEXT;
        state_d = S_FMRG;
      end
      S_FMRG: begin
        op      = C_MERGE;
        state_d = S_MSR;
      end
      // close the gap left by merged neighbors
      S_MSR: begin
        if (stat_i.mshift_more) begin
          op      = C_MSH_READ;
          state_d = S_MSW;
        end else begin
          op      = C_MDONE;
          st_d    = ST_OK;
          state_d = S_RESULT;
        end
      end
      S_MSW: begin
        op      = C_MSH_WRITE;
        state_d = S_MSR;
      end
      S_RESULT: begin
        op      = C_RESULT;
        state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign cmd_o.op = op;
  assign cmd_o.st = st_q;
  assign busy     = (state_q != S_IDLE);

endmodule

// File: sv/fit_policy_segment_allocator.sv
// Top level of the first/best/worst/next fit segment allocator.
// Operation: one table scan (read and evaluate per segment), then one shift per entry moved
// by a split or merge; the result word is registered in the result state after the last step.
// Throughput: one request at a time, busy high from accept until the result strobe.
// Reset: table holds one free segment of 1000 units; entry 0 is written in the init state,
// entered on reset and after a pool_size write seen while idle without start (busy high there).
// The result strobe lasts one cycle; the receiver cannot stall it.
module fit_policy_segment_allocator import fpsa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int UNIT_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pool_size_we_i,
  input  logic [UNIT_BITS-1:0] pool_size_i,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op_i,
  input  logic [1:0]           fit_policy_i,
  input  logic [UNIT_BITS-1:0] req_size_i,
  input  logic [UNIT_BITS-1:0] block_offset_i,
  output logic                 done_o,
  output logic [2:0]           status_o,
  output logic [UNIT_BITS-1:0] granted_offset_o,
  output logic [UNIT_BITS-1:0] granted_size_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fpsa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .pool_size_we_i (pool_size_we_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy)
  );

  fpsa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .UNIT_BITS    (UNIT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pool_size_we_i   (pool_size_we_i),
    .pool_size_i      (pool_size_i),
    .op_i             (op_i),
    .fit_policy_i     (fit_policy_i),
    .req_size_i       (req_size_i),
    .block_offset_i   (block_offset_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .granted_size_o   (granted_size_o)
  );

endmodule

// File: sim/fit_policy_segment_allocator_tb.sv
// Self-checking testbench for the fit-policy segment allocator.
`timescale 1ns / 100ps

module fit_policy_segment_allocator_tb;
  import fpsa_pkg::*;

  localparam int NSEG       = 64;
  localparam int NUM_RANDOM = 1068;
  localparam int WDOG_LIMIT = 40000;

  typedef struct {
    logic    op;
    policy_e pol;
    logic [15:0] size;
    logic [15:0] offs;
    bit      has_exp;
    status_e exp_st;
    logic [15:0] exp_off;
    logic [15:0] exp_size;
  } dir_row_t;

  typedef struct {
    status_e st;
    logic [15:0] offs;
    logic [15:0] size;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        pool_size_we_i = 1'b0;
  logic [15:0] pool_size_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = 1'b0;
  logic [1:0]  fit_policy_i = '0;
  logic [15:0] req_size_i = '0;
  logic [15:0] block_offset_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] granted_offset_o;
  logic [15:0] granted_size_o;

  fit_policy_segment_allocator dut (.*);

  always #10 clk_i = ~clk_i;

  // shadow segment table
  logic [15:0] sh_size [NSEG];
  logic        sh_used [NSEG];
  int          sh_count;
  logic [15:0] sh_next;
  logic [15:0] sh_pool;

  grant_t grants_pending[$];
  int     n_mismatch, n_words, n_alloc_ok, n_free_ok, n_err;
  int     wdog;
  bit     timed_out;

  function automatic void table_reset(logic [15:0] psize);
    for (int i = 0; i < NSEG; i++) begin
      sh_size[i] = '0;
      sh_used[i] = 1'b0;
    end
    sh_pool = psize;
    sh_size[0] = psize;
    sh_count = 1;
    sh_next = '0;
  endfunction

  function automatic logic [15:0] seg_start(int idx);
    logic [15:0] acc;
    acc = '0;
    for (int i = 0; i < idx && i < sh_count; i++) acc = acc + sh_size[i];
    return acc;
  endfunction

  function automatic bit bool_fit(int i, logic [15:0] req);
    return !sh_used[i] && sh_size[i] >= req;
  endfunction

  function automatic int pick_segment(policy_e pol, logic [15:0] req);
    int pick, s, j;
    logic [15:0] acc;
    pick = -1;
    if (pol != POL_NEXT) begin
      for (int i = 0; i < sh_count; i++) begin
        if (!bool_fit(i, req)) continue;
        if (pol == POL_FIRST) return i;
        if (pick < 0 || (pol == POL_BEST && sh_size[i] < sh_size[pick]) ||
            (pol == POL_WORST && sh_size[i] > sh_size[pick])) pick = i;
      end
      return pick;
    end
    s = 0;
    acc = '0;
    for (int i = 0; i < sh_count; i++) begin
      if (sh_next >= acc && 17'(sh_next) < 17'(acc) + 17'(sh_size[i])) begin
        s = i;
        break;
      end
      acc = acc + sh_size[i];
    end
    for (int k = 0; k < sh_count; k++) begin
      j = s + k;
      if (j >= sh_count) j -= sh_count;
      if (bool_fit(j, req)) return j;
    end
    return -1;
  endfunction

  function automatic void drop_entry(int r);
    for (int j = r; j + 1 < sh_count; j++) begin
      sh_size[j] = sh_size[j+1];
      sh_used[j] = sh_used[j+1];
    end
    sh_count--;
    sh_size[sh_count] = '0;
    sh_used[sh_count] = 1'b0;
  endfunction

  function automatic grant_t serve_request(logic op, policy_e pol, logic [15:0] req,
                                           logic [15:0] offs);
    grant_t g;
    int i, hit;
    logic [15:0] acc;
    g = '{ST_OK, '0, '0};
    if (!op) begin
      if (req == 0) begin
        g.st = ST_ZERO;
        return g;
      end
      i = pick_segment(pol, req);
      if (i < 0) begin
        g.st = ST_NOFIT;
        return g;
      end
      if (sh_size[i] > req && sh_count >= NSEG) begin
        g.st = ST_FULL;
        return g;
      end
      if (sh_size[i] > req) begin
        for (int j = sh_count; j > i + 1; j--) begin
          sh_size[j] = sh_size[j-1];
          sh_used[j] = sh_used[j-1];
        end
        sh_size[i+1] = sh_size[i] - req;
        sh_used[i+1] = 1'b0;
        sh_count++;
        sh_size[i] = req;
      end
      sh_used[i] = 1'b1;
      g.offs = seg_start(i);
      g.size = sh_size[i];
      sh_next = g.offs;
      return g;
    end
    hit = -1;
    acc = '0;
    for (int k = 0; k < sh_count; k++) begin
      if (acc == offs && sh_used[k] && sh_size[k] > 0) begin
        hit = k;
        break;
      end
      acc = acc + sh_size[k];
    end
    if (hit < 0) begin
      g.st = ST_BADFREE;
      return g;
    end
    i = hit;
    sh_used[i] = 1'b0;
    if (i > 0 && !sh_used[i-1]) begin
      sh_size[i-1] = sh_size[i-1] + sh_size[i];
      drop_entry(i);
      i--;
    end
    if (i + 1 < sh_count && !sh_used[i+1]) begin
      sh_size[i] = sh_size[i] + sh_size[i+1];
      drop_entry(i + 1);
    end
    g.offs = seg_start(i);
    g.size = sh_size[i];
    return g;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_words++;
      if (grants_pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word: st=%0d off=%0d size=%0d",
                                       status_o, granted_offset_o, granted_size_o);
      end else begin
        grant_t e;
        e = grants_pending.pop_front();
        if (status_o !== e.st || granted_offset_o !== e.offs ||
            granted_size_o !== e.size) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp st=%0d off=%0d size=%0d, got st=%0d off=%0d size=%0d",
                     e.st, e.offs, e.size, status_o, granted_offset_o, granted_size_o);
        end
        if (e.st != ST_OK) n_err++;
      end
    end
  end

  // watchdog: cycles without any accept or result word
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    start <= 1'b0;
    repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(posedge clk_i);
  endtask

  // Issue one request word; holds start until accepted.
  task automatic send_request(logic op, policy_e pol, logic [15:0] req, logic [15:0] offs,
                              bit has_exp, grant_t ex);
    grant_t g;
    start <= 1'b1;
    op_i <= op;
    fit_policy_i <= pol;
    req_size_i <= req;
    block_offset_i <= offs;
    do @(posedge clk_i); while (busy);
    g = serve_request(op, pol, req, offs);
    if (has_exp && (g.st != ex.st || g.offs != ex.offs || g.size != ex.size)) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("predictor disagrees with table row: op=%0d req=%0d", op,
                                     req);
    end
    grants_pending.push_back(g);
    if (g.st == ST_OK) begin
      if (op) n_free_ok++;
      else n_alloc_ok++;
    end
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (grants_pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_pool(logic [15:0] psize);
    drain_and_settle();
    pool_size_we_i <= 1'b1;
    pool_size_i <= psize;
    @(posedge clk_i);
    pool_size_we_i <= 1'b0;
    table_reset(psize);
  endtask

  // pick an offset that is a used block start, or noise
  function automatic logic [15:0] free_target();
    int n;
    int idx [$];
    for (int i = 0; i < sh_count; i++) if (sh_used[i]) idx.push_back(i);
    if (idx.size() != 0 && $urandom_range(0, 9) < 8)
      return seg_start(idx[$urandom_range(0, idx.size() - 1)]);
    n = $urandom_range(0, 2);
    if (n == 0) return 16'($urandom);
    if (n == 1) return seg_start($urandom_range(0, sh_count - 1));
    return seg_start($urandom_range(0, sh_count - 1)) + 16'd1;
  endfunction

  function automatic logic [15:0] pick_size(int mode);
    if (mode == 0) return 16'($urandom_range(1, 4));
    if (mode == 1) return 16'($urandom_range(1, sh_pool > 64 ? sh_pool / 16 : 4));
    if (mode == 2) return 16'($urandom);
    return 16'($urandom_range(0, 40));
  endfunction

  dir_row_t dir_rows[] = '{
    '{1'b0, POL_FIRST, 16'd0,   16'd0, 1'b1, ST_ZERO,    16'd0,   16'd0},
    '{1'b0, POL_FIRST, 16'd1001, 16'd0, 1'b1, ST_NOFIT,  16'd0,   16'd0},
    '{1'b0, POL_FIRST, 16'hFFFF, 16'd0, 1'b1, ST_NOFIT,  16'd0,   16'd0},
    '{1'b1, POL_FIRST, 16'd0,   16'd0, 1'b1, ST_BADFREE, 16'd0,   16'd0},
    '{1'b0, POL_FIRST, 16'd100, 16'd0, 1'b1, ST_OK,      16'd0,   16'd100},
    '{1'b0, POL_BEST,  16'd50,  16'd0, 1'b1, ST_OK,      16'd100, 16'd50},
    '{1'b0, POL_WORST, 16'd200, 16'd0, 1'b1, ST_OK,      16'd150, 16'd200},
    '{1'b0, POL_NEXT,  16'd10,  16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b1, POL_FIRST, 16'd0,  16'd100, 1'b0, ST_OK,     16'd0,   16'd0},
    '{1'b1, POL_FIRST, 16'd0,  16'd120, 1'b1, ST_BADFREE, 16'd0,  16'd0},
    '{1'b0, POL_BEST,  16'd50,  16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b0, POL_FIRST, 16'd40,  16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b1, POL_FIRST, 16'd0,  16'd150, 1'b0, ST_OK,     16'd0,   16'd0},
    '{1'b1, POL_FIRST, 16'd0,   16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b0, POL_NEXT,  16'd5,   16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b0, POL_WORST, 16'd1,   16'd0, 1'b0, ST_OK,      16'd0,   16'd0},
    '{1'b1, POL_NEXT,  16'hFFFF, 16'hFFFF, 1'b1, ST_BADFREE, 16'd0, 16'd0}
  };

  initial begin
    int phase_sizes[6] = '{1000, 65535, 1, 0, 300, 2000};
    int mode;
    logic op;
    table_reset(16'd1000);
    n_mismatch = 0; n_words = 0; n_alloc_ok = 0; n_free_ok = 0; n_err = 0;
    wdog = 0;
    timed_out = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      grant_t ex;
      ex = '{dir_rows[r].exp_st, dir_rows[r].exp_off, dir_rows[r].exp_size};
      send_request(dir_rows[r].op, dir_rows[r].pol, dir_rows[r].size, dir_rows[r].offs,
                   dir_rows[r].has_exp, ex);
    end

    // table-full case: fill 64 entries with unit allocs on a big pool
    set_pool(16'd200);
    for (int k = 0; k < 66; k++) send_request(1'b0, POL_FIRST, 16'd1, 16'd0, 1'b0, '{ST_OK, 0, 0});
    send_request(1'b0, POL_FIRST, 16'd2, 16'd0, 1'b0, '{ST_OK, 0, 0});

    for (int p = 0; p < 6; p++) begin
      set_pool(16'(phase_sizes[p]));
      for (int k = 0; k < NUM_RANDOM / 6; k++) begin
        idle_gap();
        mode = $urandom_range(0, 9);
        op = ($urandom_range(0, 99) < 45);
        if (op)
          send_request(1'b1, policy_e'($urandom_range(0, 3)), 16'($urandom), free_target(),
                       1'b0, '{ST_OK, 0, 0});
        else
          send_request(1'b0, policy_e'($urandom_range(0, 3)),
                       pick_size(mode < 3 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3),
                       16'($urandom), 1'b0, '{ST_OK, 0, 0});
      end
    end

    drain_and_settle();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d result words: %0d good allocates, %0d good frees, %0d error codes,",
             n_words, n_alloc_ok, n_free_ok, n_err);
    $display("over pool sizes 1000, 65535, 1, 0, 300, 2000 and a full table.");
    if (n_mismatch == 0 && grants_pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
